// ----- hdl/prr_pkg.sv -----
`timescale 1ns / 1ps
// shared constants, types and microcode program of the ptz pattern record/replay unit
package prr_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int UPC_W       = 5;

   // input item kinds
   localparam logic [2:0] KIND_POS  = 3'd0;
   localparam logic [2:0] KIND_CMD  = 3'd1;
   localparam logic [2:0] KIND_REC  = 3'd2;
   localparam logic [2:0] KIND_STOP = 3'd3;
   localparam logic [2:0] KIND_PLAY = 3'd4;
   localparam logic [2:0] KIND_TICK = 3'd5;

   // result kinds
   localparam logic [1:0] RK_STATUS = 2'd0;
   localparam logic [1:0] RK_GOTO   = 2'd1;
   localparam logic [1:0] RK_CMD    = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_REFUSED = 2'd1;
   localparam logic [1:0] ST_EMPTY   = 2'd2;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_FETCH,
      OP_APPEND,
      OP_REC_START,
      OP_STOP,
      OP_PLAY_START,
      OP_TICK,
      OP_READ_IDX,
      OP_TAKE,
      OP_READ_ZERO,
      OP_FLUSH,
      OP_FLUSH_END,
      OP_GOTO,
      OP_STATUS
   } op_type;

   typedef enum logic [3:0] {
      J_NONE,
      J_ALWAYS,
      J_DISPATCH,
      J_IF_REC,
      J_IF_NOT_REC,
      J_IF_PLAY,
      J_IF_NOT_PLAY,
      J_IF_PHASE0,
      J_IF_IDX_END,
      J_IF_IDX_MORE,
      J_IF_CNT_ZERO,
      J_IF_NOT_LATER
   } jump_type;

   // microcode addresses
   localparam logic [UPC_W-1:0] U_FETCH  = 5'd0;
   localparam logic [UPC_W-1:0] U_DISP   = 5'd1;
   localparam logic [UPC_W-1:0] U_POS0   = 5'd2;
   localparam logic [UPC_W-1:0] U_POS1   = 5'd3;
   localparam logic [UPC_W-1:0] U_POS2   = 5'd4;
   localparam logic [UPC_W-1:0] U_LCHK   = 5'd5;
   localparam logic [UPC_W-1:0] U_LRD    = 5'd6;
   localparam logic [UPC_W-1:0] U_LCMP   = 5'd7;
   localparam logic [UPC_W-1:0] U_LTAKE  = 5'd8;
   localparam logic [UPC_W-1:0] U_LNEXT  = 5'd9;
   localparam logic [UPC_W-1:0] U_GOTO0  = 5'd10;
   localparam logic [UPC_W-1:0] U_GOTO1  = 5'd11;
   localparam logic [UPC_W-1:0] U_GOTO2  = 5'd12;
   localparam logic [UPC_W-1:0] U_END    = 5'd13;
   localparam logic [UPC_W-1:0] U_CMD0   = 5'd14;
   localparam logic [UPC_W-1:0] U_APP    = 5'd15;
   localparam logic [UPC_W-1:0] U_REC0   = 5'd16;
   localparam logic [UPC_W-1:0] U_REC1   = 5'd17;
   localparam logic [UPC_W-1:0] U_REC2   = 5'd18;
   localparam logic [UPC_W-1:0] U_STOP0  = 5'd19;
   localparam logic [UPC_W-1:0] U_OK     = 5'd20;
   localparam logic [UPC_W-1:0] U_PLAY0  = 5'd21;
   localparam logic [UPC_W-1:0] U_PLAY1  = 5'd22;
   localparam logic [UPC_W-1:0] U_PLAY2  = 5'd23;
   localparam logic [UPC_W-1:0] U_REFUSE = 5'd24;
   localparam logic [UPC_W-1:0] U_EMPTY  = 5'd25;
   localparam logic [UPC_W-1:0] U_TICK   = 5'd26;
   localparam logic [UPC_W-1:0] U_LAST   = 5'd26;

   typedef struct packed {
      op_type             op;
      jump_type           jump;
      logic [UPC_W-1:0]   target;
      logic [1:0]         status;
   } ctrl_word_type;

   typedef struct packed {
      logic       stall;
      logic [2:0] kind;
      logic       rec_on;
      logic       play_on;
      logic       phase_run;
      logic       idx_end;
      logic       cnt_zero;
      logic       later;
   } flags_type;

   typedef struct packed {
      logic [47:0] pos;
      logic        is_cmd;
      logic [7:0]  code;
      logic [63:0] params;
      logic [31:0] stamp;
   } entry_type;

   typedef struct packed {
      logic [1:0]         result_kind;
      logic [1:0]         status;
      logic signed [15:0] target_pan;
      logic signed [15:0] target_tilt;
      logic signed [15:0] target_zoom;
      logic [7:0]         out_cmd;
      logic [31:0]        out_param_a;
      logic [31:0]        out_param_b;
      logic               last;
   } rsp_type;

   function automatic ctrl_word_type mk_word(input op_type op, input jump_type jump,
                                             input logic [UPC_W-1:0] target,
                                             input logic [1:0] status);
      ctrl_word_type w;
      w.op     = op;
      w.jump   = jump;
      w.target = target;
      w.status = status;
      return w;
   endfunction

   // control program: one word per step
   function automatic ctrl_word_type ucode(input logic [UPC_W-1:0] upc);
      ctrl_word_type w;
      case (upc)
         U_FETCH:  w = mk_word(OP_FETCH,      J_NONE,         U_FETCH,  ST_OK);
         U_DISP:   w = mk_word(OP_NOP,        J_DISPATCH,     U_FETCH,  ST_OK);
         U_POS0:   w = mk_word(OP_NOP,        J_IF_REC,       U_APP,    ST_OK);
         U_POS1:   w = mk_word(OP_NOP,        J_IF_NOT_PLAY,  U_FETCH,  ST_OK);
         U_POS2:   w = mk_word(OP_NOP,        J_IF_PHASE0,    U_GOTO0,  ST_OK);
         U_LCHK:   w = mk_word(OP_NOP,        J_IF_IDX_END,   U_GOTO0,  ST_OK);
         U_LRD:    w = mk_word(OP_READ_IDX,   J_NONE,         U_FETCH,  ST_OK);
         U_LCMP:   w = mk_word(OP_NOP,        J_IF_NOT_LATER, U_END,    ST_OK);
         U_LTAKE:  w = mk_word(OP_TAKE,       J_NONE,         U_FETCH,  ST_OK);
         U_LNEXT:  w = mk_word(OP_NOP,        J_IF_IDX_MORE,  U_LCMP,   ST_OK);
         U_GOTO0:  w = mk_word(OP_READ_ZERO,  J_NONE,         U_FETCH,  ST_OK);
         U_GOTO1:  w = mk_word(OP_FLUSH,      J_NONE,         U_FETCH,  ST_OK);
         U_GOTO2:  w = mk_word(OP_GOTO,       J_ALWAYS,       U_FETCH,  ST_OK);
         U_END:    w = mk_word(OP_FLUSH_END,  J_ALWAYS,       U_FETCH,  ST_OK);
         U_CMD0:   w = mk_word(OP_NOP,        J_IF_NOT_REC,   U_FETCH,  ST_OK);
         U_APP:    w = mk_word(OP_APPEND,     J_ALWAYS,       U_FETCH,  ST_OK);
         U_REC0:   w = mk_word(OP_NOP,        J_IF_PLAY,      U_REFUSE, ST_OK);
         U_REC1:   w = mk_word(OP_REC_START,  J_NONE,         U_FETCH,  ST_OK);
         U_REC2:   w = mk_word(OP_APPEND,     J_ALWAYS,       U_OK,     ST_OK);
         U_STOP0:  w = mk_word(OP_STOP,       J_NONE,         U_FETCH,  ST_OK);
         U_OK:     w = mk_word(OP_STATUS,     J_ALWAYS,       U_FETCH,  ST_OK);
         U_PLAY0:  w = mk_word(OP_NOP,        J_IF_REC,       U_REFUSE, ST_OK);
         U_PLAY1:  w = mk_word(OP_NOP,        J_IF_CNT_ZERO,  U_EMPTY,  ST_OK);
         U_PLAY2:  w = mk_word(OP_PLAY_START, J_ALWAYS,       U_OK,     ST_OK);
         U_REFUSE: w = mk_word(OP_STATUS,     J_ALWAYS,       U_FETCH,  ST_REFUSED);
         U_EMPTY:  w = mk_word(OP_STATUS,     J_ALWAYS,       U_FETCH,  ST_EMPTY);
         U_TICK:   w = mk_word(OP_TICK,       J_ALWAYS,       U_FETCH,  ST_OK);
         default:  w = mk_word(OP_NOP,        J_ALWAYS,       U_FETCH,  ST_OK);
      endcase
      return w;
   endfunction

   // entry point of each item kind
   function automatic logic [UPC_W-1:0] dispatch(input logic [2:0] kind);
      logic [UPC_W-1:0] a;
      case (kind)
         KIND_POS:  a = U_POS0;
         KIND_CMD:  a = U_CMD0;
         KIND_REC:  a = U_REC0;
         KIND_STOP: a = U_STOP0;
         KIND_PLAY: a = U_PLAY0;
         KIND_TICK: a = U_TICK;
         default:   a = U_FETCH;
      endcase
      return a;
   endfunction

endpackage

// ----- hdl/prr_if.sv -----
`timescale 1ns / 1ps
// valid/ready channel interfaces for request and response items
interface prr_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         kind;
   logic signed [15:0] pan;
   logic signed [15:0] tilt;
   logic signed [15:0] zoom;
   logic [7:0]         cmd_code;
   logic [31:0]        param_a;
   logic [31:0]        param_b;

   modport source (output valid, kind, pan, tilt, zoom, cmd_code, param_a, param_b,
                   input ready);
   modport sink (input valid, kind, pan, tilt, zoom, cmd_code, param_a, param_b,
                 output ready);
endinterface

interface prr_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         result_kind;
   logic [1:0]         status;
   logic signed [15:0] target_pan;
   logic signed [15:0] target_tilt;
   logic signed [15:0] target_zoom;
   logic [7:0]         out_cmd;
   logic [31:0]        out_param_a;
   logic [31:0]        out_param_b;
   logic               last;

   modport source (output valid, result_kind, status, target_pan, target_tilt, target_zoom,
                   out_cmd, out_param_a, out_param_b, last,
                   input ready);
   modport sink (input valid, result_kind, status, target_pan, target_tilt, target_zoom,
                 out_cmd, out_param_a, out_param_b, last,
                 output ready);
endinterface

// ----- hdl/prr_sequencer.sv -----
`timescale 1ns / 1ps
// microcode step counter with conditional jumps and kind dispatch
module prr_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  prr_pkg::flags_type     flags,
   output prr_pkg::ctrl_word_type ctrl
);

   logic [prr_pkg::UPC_W-1:0] upc_ff;
   logic [prr_pkg::UPC_W-1:0] upc_in;
   logic                      take;

   assign ctrl = prr_pkg::ucode(upc_ff);

   always_comb begin
      case (ctrl.jump)
         prr_pkg::J_NONE:         take = 1'b0;
         prr_pkg::J_ALWAYS:       take = 1'b1;
         prr_pkg::J_DISPATCH:     take = 1'b0;
         prr_pkg::J_IF_REC:       take = flags.rec_on;
         prr_pkg::J_IF_NOT_REC:   take = !flags.rec_on;
         prr_pkg::J_IF_PLAY:      take = flags.play_on;
         prr_pkg::J_IF_NOT_PLAY:  take = !flags.play_on;
         prr_pkg::J_IF_PHASE0:    take = !flags.phase_run;
         prr_pkg::J_IF_IDX_END:   take = flags.idx_end;
         prr_pkg::J_IF_IDX_MORE:  take = !flags.idx_end;
         prr_pkg::J_IF_CNT_ZERO:  take = flags.cnt_zero;
         prr_pkg::J_IF_NOT_LATER: take = !flags.later;
         default:                 take = 1'b0;
      endcase

      if (flags.stall) begin
         upc_in = upc_ff;
      end else if (ctrl.jump == prr_pkg::J_DISPATCH) begin
         upc_in = prr_pkg::dispatch(flags.kind);
      end else if (take) begin
         upc_in = ctrl.target;
      end else begin
         upc_in = upc_ff + prr_pkg::UPC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= prr_pkg::U_FETCH;
      end else begin
         upc_ff <= upc_in;
      end
   end

   a_upc_in_program: assert property (@(posedge clock) disable iff (reset)
      upc_ff <= prr_pkg::U_LAST)
      else $error("step counter left the program");

   a_jump_only_no_stall: assert property (@(posedge clock) disable iff (reset)
      ctrl.op == prr_pkg::OP_NOP |-> !flags.stall)
      else $error("jump-only step stalled");

   a_fetch_then_dispatch: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == prr_pkg::OP_FETCH && !flags.stall) |=> upc_ff == prr_pkg::U_DISP)
      else $error("accepted item not dispatched");

endmodule

// ----- hdl/prr_datapath.sv -----
`timescale 1ns / 1ps
// pattern table, mode state, timer, pending-command hold and response register
module prr_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  prr_pkg::ctrl_word_type ctrl,
   output prr_pkg::flags_type     flags,
   prr_req_if.sink                req_chan,
   prr_rsp_if.source              rsp_chan
);

   // latched item
   logic [2:0]                 kind_ff,  kind_in;
   logic [47:0]                pos_ff,   pos_in;
   logic [7:0]                 code_ff,  code_in;
   logic [63:0]                params_ff, params_in;

   // mode and table state
   logic                       rec_ff,   rec_in;
   logic                       play_ff,  play_in;
   logic                       phase_ff, phase_in;
   logic [prr_pkg::CNT_W-1:0]  idx_ff,   idx_in;
   logic [prr_pkg::CNT_W-1:0]  cnt_ff,   cnt_in;
   logic [31:0]                elapsed_ff, elapsed_in;

   // command waiting until it is known whether it ends the step
   logic                       hold_valid_ff, hold_valid_in;
   logic [7:0]                 hold_code_ff,  hold_code_in;
   logic [63:0]                hold_params_ff, hold_params_in;

   logic                       out_valid_ff, out_valid_in;
   prr_pkg::rsp_type           out_ff, out_in;

   prr_pkg::entry_type         mem [prr_pkg::TABLE_DEPTH];
   prr_pkg::entry_type         rd_ff;
   prr_pkg::entry_type         wr_entry;
   logic                       wr_en;
   logic                       rd_en;
   logic [prr_pkg::ADDR_W-1:0] rd_addr;
   logic [prr_pkg::CNT_W-1:0]  idx_next;

   logic                       push_need;
   logic                       out_free;
   logic                       stall;

   assign idx_next = idx_ff + prr_pkg::CNT_W'(1);
   assign out_free = !out_valid_ff || rsp_chan.ready;

   always_comb begin
      case (ctrl.op)
         prr_pkg::OP_STATUS,
         prr_pkg::OP_GOTO:      push_need = 1'b1;
         prr_pkg::OP_FLUSH,
         prr_pkg::OP_FLUSH_END: push_need = hold_valid_ff;
         prr_pkg::OP_TAKE:      push_need = hold_valid_ff && rd_ff.is_cmd;
         default:               push_need = 1'b0;
      endcase
      stall = (ctrl.op == prr_pkg::OP_FETCH && !req_chan.valid) || (push_need && !out_free);
   end

   assign req_chan.ready = (ctrl.op == prr_pkg::OP_FETCH);

   assign flags.stall     = stall;
   assign flags.kind      = kind_ff;
   assign flags.rec_on    = rec_ff;
   assign flags.play_on   = play_ff;
   assign flags.phase_run = phase_ff;
   assign flags.idx_end   = (idx_ff >= cnt_ff);
   assign flags.cnt_zero  = (cnt_ff == '0);
   assign flags.later     = (elapsed_ff > rd_ff.stamp);

   assign wr_entry.pos    = pos_ff;
   assign wr_entry.is_cmd = (kind_ff == prr_pkg::KIND_CMD);
   assign wr_entry.code   = code_ff;
   assign wr_entry.params = params_ff;
   assign wr_entry.stamp  = elapsed_ff;

   always_comb begin
      kind_in        = kind_ff;
      pos_in         = pos_ff;
      code_in        = code_ff;
      params_in      = params_ff;
      rec_in         = rec_ff;
      play_in        = play_ff;
      phase_in       = phase_ff;
      idx_in         = idx_ff;
      cnt_in         = cnt_ff;
      elapsed_in     = elapsed_ff;
      hold_valid_in  = hold_valid_ff;
      hold_code_in   = hold_code_ff;
      hold_params_in = hold_params_ff;
      out_valid_in   = out_valid_ff && !rsp_chan.ready;
      out_in         = out_ff;
      wr_en          = 1'b0;
      rd_en          = 1'b0;
      rd_addr        = '0;

      if (!stall) begin
         case (ctrl.op)
            prr_pkg::OP_FETCH: begin
               kind_in   = req_chan.kind;
               pos_in    = {req_chan.zoom, req_chan.tilt, req_chan.pan};
               code_in   = req_chan.cmd_code;
               params_in = {req_chan.param_b, req_chan.param_a};
            end
            prr_pkg::OP_APPEND: begin
               // a full table drops the entry
               if (cnt_ff < prr_pkg::CNT_W'(prr_pkg::TABLE_DEPTH)) begin
                  wr_en  = 1'b1;
                  cnt_in = cnt_ff + prr_pkg::CNT_W'(1);
               end
            end
            prr_pkg::OP_REC_START: begin
               cnt_in     = '0;
               rec_in     = 1'b1;
               elapsed_in = '0;
            end
            prr_pkg::OP_STOP: begin
               rec_in  = 1'b0;
               play_in = 1'b0;
            end
            prr_pkg::OP_PLAY_START: begin
               play_in    = 1'b1;
               elapsed_in = '0;
               idx_in     = '0;
               phase_in   = 1'b0;
            end
            prr_pkg::OP_TICK: begin
               if (elapsed_ff != '1) begin
                  elapsed_in = elapsed_ff + 32'd1;
               end
            end
            prr_pkg::OP_READ_IDX: begin
               rd_en   = 1'b1;
               rd_addr = idx_ff[prr_pkg::ADDR_W-1:0];
            end
            prr_pkg::OP_TAKE: begin
               if (rd_ff.is_cmd) begin
                  if (hold_valid_ff) begin
                     out_valid_in            = 1'b1;
                     out_in                  = '0;
                     out_in.result_kind      = prr_pkg::RK_CMD;
                     out_in.out_cmd          = hold_code_ff;
                     out_in.out_param_a      = hold_params_ff[31:0];
                     out_in.out_param_b      = hold_params_ff[63:32];
                  end
                  hold_valid_in  = 1'b1;
                  hold_code_in   = rd_ff.code;
                  hold_params_in = rd_ff.params;
               end
               idx_in  = idx_next;
               // prefetch the following entry for the next compare
               rd_en   = 1'b1;
               rd_addr = idx_next[prr_pkg::ADDR_W-1:0];
            end
            prr_pkg::OP_READ_ZERO: begin
               rd_en   = 1'b1;
               rd_addr = '0;
            end
            prr_pkg::OP_FLUSH,
            prr_pkg::OP_FLUSH_END: begin
               if (hold_valid_ff) begin
                  out_valid_in       = 1'b1;
                  out_in             = '0;
                  out_in.result_kind = prr_pkg::RK_CMD;
                  out_in.out_cmd     = hold_code_ff;
                  out_in.out_param_a = hold_params_ff[31:0];
                  out_in.out_param_b = hold_params_ff[63:32];
                  out_in.last        = (ctrl.op == prr_pkg::OP_FLUSH_END);
               end
               hold_valid_in = 1'b0;
            end
            prr_pkg::OP_GOTO: begin
               out_valid_in       = 1'b1;
               out_in             = '0;
               out_in.result_kind = prr_pkg::RK_GOTO;
               out_in.target_pan  = rd_ff.pos[15:0];
               out_in.target_tilt = rd_ff.pos[31:16];
               out_in.target_zoom = rd_ff.pos[47:32];
               out_in.last        = 1'b1;
               phase_in           = 1'b1;
               idx_in             = '0;
               elapsed_in         = '0;
            end
            prr_pkg::OP_STATUS: begin
               out_valid_in       = 1'b1;
               out_in             = '0;
               out_in.result_kind = prr_pkg::RK_STATUS;
               out_in.status      = ctrl.status;
               out_in.last        = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_ff        <= 1'b0;
         play_ff       <= 1'b0;
         phase_ff      <= 1'b0;
         idx_ff        <= '0;
         cnt_ff        <= '0;
         elapsed_ff    <= '0;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         rec_ff        <= rec_in;
         play_ff       <= play_in;
         phase_ff      <= phase_in;
         idx_ff        <= idx_in;
         cnt_ff        <= cnt_in;
         elapsed_ff    <= elapsed_in;
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      pos_ff         <= pos_in;
      code_ff        <= code_in;
      params_ff      <= params_in;
      hold_code_ff   <= hold_code_in;
      hold_params_ff <= hold_params_in;
      out_ff         <= out_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[cnt_ff[prr_pkg::ADDR_W-1:0]] <= wr_entry;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.result_kind = out_ff.result_kind;
   assign rsp_chan.status      = out_ff.status;
   assign rsp_chan.target_pan  = out_ff.target_pan;
   assign rsp_chan.target_tilt = out_ff.target_tilt;
   assign rsp_chan.target_zoom = out_ff.target_zoom;
   assign rsp_chan.out_cmd     = out_ff.out_cmd;
   assign rsp_chan.out_param_a = out_ff.out_param_a;
   assign rsp_chan.out_param_b = out_ff.out_param_b;
   assign rsp_chan.last        = out_ff.last;

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= prr_pkg::CNT_W'(prr_pkg::TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_modes_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(rec_ff && play_ff))
      else $error("recording and replaying at once");

   a_hold_only_in_replay: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff |-> play_ff)
      else $error("pending command outside replay");

   a_replay_index_bound: assert property (@(posedge clock) disable iff (reset)
      play_ff |-> (idx_ff <= cnt_ff && cnt_ff != '0))
      else $error("replay index beyond table or empty table in replay");

   a_hold_flushed_at_fetch: assert property (@(posedge clock) disable iff (reset)
      ctrl.op == prr_pkg::OP_FETCH |-> !hold_valid_ff)
      else $error("pending command left behind at end of step");

endmodule

// ----- hdl/ptz_pattern_record_replay_unit.sv -----
`timescale 1ns / 1ps
// top level of the ptz pattern record/replay unit
//
//   channel    dir   handshake      carries
//   req_chan   in    valid/ready    kind, pan, tilt, zoom, cmd_code, param_a, param_b
//   rsp_chan   out   valid/ready    result_kind, status, target_*, out_cmd, out_param_*, last
//
// one item at a time: the next item is taken only after the step for the last one ends
// a position update in replay goes straight to a goto in goto phase, else walks the
// table entries whose stamps the timer has passed, one table read per step through the
// single table port, and wraps to a goto when the walk reaches the end of the table
// synchronous reset clears modes, count, index and timer; the table is not cleared
// a full response register stalls the step that emits until rsp_chan.ready
module ptz_pattern_record_replay_unit (
   input  logic      clock,
   input  logic      reset,
   prr_req_if.sink   req_chan,
   prr_rsp_if.source rsp_chan
);

   prr_pkg::ctrl_word_type ctrl;
   prr_pkg::flags_type     flags;

   prr_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   prr_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .flags    (flags),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

endmodule
